// ----- sv/fbc_pkg.sv -----
// Package for the frustum box cull core: shared constants, plane tables and
// the stage-enable struct. Used by every other file in this folder.
package fbc_pkg;

  // Default widths of box coordinates and matrix entries.
  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned COEF_WIDTH_DEF  = 16;

  // Matrix entries sit in 16-bit lanes of each 64-bit column register.
  localparam int unsigned COEF_LANE   = 16;
  localparam int unsigned COORD_FRAC  = 8;
  localparam int unsigned PLANE_COUNT = 6;
  localparam int unsigned AXIS_COUNT  = 3;
  localparam int unsigned TAG_WIDTH   = 32;

  // Configuration port.
  localparam int unsigned CFG_WIDTH     = 64;
  localparam int unsigned CFG_IDX_WIDTH = 3;
  localparam int unsigned COL_COUNT     = 4;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_MATRIX_COL0 = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MATRIX_COL1 = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MATRIX_COL2 = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_MATRIX_COL3 = 3'd3;

  // Row 3 is the base of every plane; the other row is added or subtracted.
  localparam int unsigned BASE_ROW = 3;
  localparam int unsigned PLANE_ROW [PLANE_COUNT] = '{0, 0, 1, 1, 2, 2};
  localparam bit          PLANE_ADD [PLANE_COUNT] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  // Load enables of the product and sum stages inside each plane unit.
  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ----- sv/fbc_plane.sv -----
// One frustum plane: corner selection, three products, and the plane distance.
// Two register stages (products, then sum). Depends on fbc_pkg.
module fbc_plane #(
  parameter int unsigned COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = fbc_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbc_pkg::stage_en_t            en_i,
  input  logic signed [COEF_WIDTH:0]    coef_i [fbc_pkg::COL_COUNT],
  input  logic signed [COORD_WIDTH-1:0] lo_i   [fbc_pkg::AXIS_COUNT],
  input  logic signed [COORD_WIDTH-1:0] hi_i   [fbc_pkg::AXIS_COUNT],
  output logic                          neg_o
);

  localparam int unsigned CW1 = COEF_WIDTH + 1;
  localparam int unsigned PW  = CW1 + COORD_WIDTH;
  localparam int unsigned SW  = PW + 2;

  logic signed [PW-1:0] prod_d  [fbc_pkg::AXIS_COUNT];
  logic signed [PW-1:0] prod_q  [fbc_pkg::AXIS_COUNT];
  logic signed [PW-1:0] const_d, const_q;
  logic signed [SW-1:0] sum_d, sum_q;

  // The corner farthest along the normal takes max only where the entry is positive.
  always_comb begin
    logic signed [COORD_WIDTH-1:0] corner;
    corner = '0;
    for (int a = 0; a < int'(fbc_pkg::AXIS_COUNT); a++) begin
      corner    = (coef_i[a] > 0) ? hi_i[a] : lo_i[a];
      prod_d[a] = PW'(coef_i[a]) * PW'(corner);
    end
    const_d = PW'(coef_i[fbc_pkg::COL_COUNT-1]) <<< fbc_pkg::COORD_FRAC;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      prod_q  <= prod_d;
      const_q <= const_d;
    end
  end

  assign sum_d = SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(const_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i.s3) begin
      sum_q <= sum_d;
    end
  end

  assign neg_o = sum_q[SW-1];

endmodule

// ----- sv/frustum_box_cull_core.sv -----
// Top level of the frustum box cull core: configuration registers, plane
// coefficients, pipeline control and result register. Depends on fbc_pkg, fbc_plane.

// Tests one axis-aligned box per request against the six frustum planes of the
// configured view-projection matrix and returns the tag with a visible flag.
// A new request can be taken every cycle unless in_stall_o is high. On its way to the
// output each request passes four registers (input register, loaded by the accepting
// edge, multiply stage, plane-sum stage, output register). A stall on the output holds
// the whole pipeline without losing anything. Plane coefficients are registered and
// rebuilt from the matrix registers in the cycle after a write, so a request may follow
// a configuration write in the next cycle.
module frustum_box_cull_core #(
  parameter int unsigned COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = fbc_pkg::COEF_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fbc_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [fbc_pkg::CFG_WIDTH-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fbc_pkg::TAG_WIDTH-1:0]        node_tag_i,
  input  logic signed [COORD_WIDTH-1:0]        min_x_i,
  input  logic signed [COORD_WIDTH-1:0]        min_y_i,
  input  logic signed [COORD_WIDTH-1:0]        min_z_i,
  input  logic signed [COORD_WIDTH-1:0]        max_x_i,
  input  logic signed [COORD_WIDTH-1:0]        max_y_i,
  input  logic signed [COORD_WIDTH-1:0]        max_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [fbc_pkg::TAG_WIDTH-1:0]        tag_out_o,
  output logic                                 visible_o
);

  localparam int unsigned NP = fbc_pkg::PLANE_COUNT;
  localparam int unsigned NC = fbc_pkg::COL_COUNT;
  localparam int unsigned NA = fbc_pkg::AXIS_COUNT;

  // Matrix columns.
  logic [fbc_pkg::CFG_WIDTH-1:0] col_q [NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < int'(NC); c++) col_q[c] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbc_pkg::REG_MATRIX_COL0: col_q[0] <= cfg_wdata_i;
        fbc_pkg::REG_MATRIX_COL1: col_q[1] <= cfg_wdata_i;
        fbc_pkg::REG_MATRIX_COL2: col_q[2] <= cfg_wdata_i;
        fbc_pkg::REG_MATRIX_COL3: col_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Plane coefficients: row 3 plus or minus another row, one entry per column.
  logic signed [COEF_WIDTH:0] coef_d [NP][NC];
  logic signed [COEF_WIDTH:0] coef_q [NP][NC];

  always_comb begin
    logic signed [COEF_WIDTH-1:0] base, other;
    base  = '0;
    other = '0;
    for (int p = 0; p < int'(NP); p++) begin
      for (int c = 0; c < int'(NC); c++) begin
        base  = col_q[c][fbc_pkg::COEF_LANE*fbc_pkg::BASE_ROW +: COEF_WIDTH];
        other = col_q[c][fbc_pkg::COEF_LANE*fbc_pkg::PLANE_ROW[p] +: COEF_WIDTH];
        if (fbc_pkg::PLANE_ADD[p]) begin
          coef_d[p][c] = (COEF_WIDTH+1)'(base) + (COEF_WIDTH+1)'(other);
        end else begin
          coef_d[p][c] = (COEF_WIDTH+1)'(base) - (COEF_WIDTH+1)'(other);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < int'(NP); p++) begin
        for (int c = 0; c < int'(NC); c++) coef_q[p][c] <= '0;
      end
    end else begin
      coef_q <= coef_d;
    end
  end

  // Pipeline control: a stage loads when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic en1, en2, en3, en_out;
  fbc_pkg::stage_en_t plane_en;

  assign en_out = !out_valid_q || !out_stall_i;
  assign en3    = !v3_q || en_out;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;

  assign plane_en.s2 = en2;
  assign plane_en.s3 = en3;
  assign in_stall_o  = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    v1_q        <= in_valid_i;
      if (en2)    v2_q        <= v1_q;
      if (en3)    v3_q        <= v2_q;
      if (en_out) out_valid_q <= v3_q;
    end
  end

  // Box registers and the tag, which follows the item through every stage.
  logic signed [COORD_WIDTH-1:0] lo_q [NA];
  logic signed [COORD_WIDTH-1:0] hi_q [NA];
  logic [fbc_pkg::TAG_WIDTH-1:0] tag1_q, tag2_q, tag3_q, tag_out_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      lo_q[0] <= min_x_i;
      lo_q[1] <= min_y_i;
      lo_q[2] <= min_z_i;
      hi_q[0] <= max_x_i;
      hi_q[1] <= max_y_i;
      hi_q[2] <= max_z_i;
      tag1_q  <= node_tag_i;
    end
    if (en2) tag2_q <= tag1_q;
    if (en3) tag3_q <= tag2_q;
  end

  logic [NP-1:0] neg;

  for (genvar p = 0; p < NP; p++) begin : g_plane
    fbc_plane #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
    ) u_plane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (plane_en),
      .coef_i (coef_q[p]),
      .lo_i   (lo_q),
      .hi_i   (hi_q),
      .neg_o  (neg[p])
    );
  end

  logic visible_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visible_q <= 1'b0;
      tag_out_q <= '0;
    end else if (en_out) begin
      visible_q <= ~|neg;
      tag_out_q <= tag3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_out_o   = tag_out_q;
  assign visible_o   = visible_q;

endmodule

// ----- sv/fbc_checker.sv -----
// Port-level checks for the frustum box cull core, and the bind that attaches
// them to frustum_box_cull_core. Depends on fbc_pkg.
module fbc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [fbc_pkg::TAG_WIDTH-1:0] tag_out_o,
  input logic                          visible_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // The input can only back up when the result at the output is held.
  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  // With a free output, the result of a request passes the input, product and sum registers
  // and then the output register, where this check samples it as valid.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(tag_out_o) && $stable(visible_o)))
    else $error("stalled result changed");

endmodule

bind frustum_box_cull_core fbc_checker u_fbc_checker (.*);

// ----- bench/cull_check_pkg.sv -----
// Request and verdict types plus the scoreboard of the frustum box cull bench.
// Holds its own copy of the view-projection matrix and predicts each verdict.
// Depends on fbc_pkg for widths and register indexes.
package cull_check_pkg;

  localparam int unsigned COORD_W = fbc_pkg::COORD_WIDTH_DEF;
  // Row 3 of the matrix is the w row, and column 3 holds the plane constants.
  localparam int W_ROW = 3;
  localparam int W_COL = 3;

  typedef struct packed {
    logic [fbc_pkg::TAG_WIDTH-1:0] tag;
    logic signed [COORD_W-1:0]     min_x;
    logic signed [COORD_W-1:0]     min_y;
    logic signed [COORD_W-1:0]     min_z;
    logic signed [COORD_W-1:0]     max_x;
    logic signed [COORD_W-1:0]     max_y;
    logic signed [COORD_W-1:0]     max_z;
  } box_t;

  typedef struct packed {
    logic [fbc_pkg::TAG_WIDTH-1:0] tag;
    logic                          visible;
  } verdict_t;

  typedef enum int {
    PLANE_W_MINUS_X,
    PLANE_W_PLUS_X,
    PLANE_W_PLUS_Y,
    PLANE_W_MINUS_Y,
    PLANE_W_MINUS_Z,
    PLANE_W_PLUS_Z
  } plane_e;

  class cull_scoreboard;
    logic [fbc_pkg::CFG_WIDTH-1:0] matrix [fbc_pkg::COL_COUNT];
    verdict_t                      pending_verdicts [$];
    int unsigned                   mismatch_count;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      mismatch_count = 0;
    endfunction

    // Writes to indexes past the last column are dropped by the block.
    function void write_reg(logic [fbc_pkg::CFG_IDX_WIDTH-1:0] idx,
                            logic [fbc_pkg::CFG_WIDTH-1:0] value);
      if (idx <= fbc_pkg::REG_MATRIX_COL3) matrix[idx[1:0]] = value;
    endfunction

    function longint coefficient(int col, int row);
      logic signed [fbc_pkg::COEF_LANE-1:0] lane;
      lane = matrix[col][row*fbc_pkg::COEF_LANE +: fbc_pkg::COEF_LANE];
      return longint'(lane);
    endfunction

    function bit predict_visible(box_t b);
      longint lo [fbc_pkg::AXIS_COUNT];
      longint hi [fbc_pkg::AXIS_COUNT];
      longint coef [fbc_pkg::COL_COUNT];
      longint plane_dist;
      int     row;
      bit     add;
      bit     culled;
      plane_e pl;
      lo[0] = longint'($signed(b.min_x));
      lo[1] = longint'($signed(b.min_y));
      lo[2] = longint'($signed(b.min_z));
      hi[0] = longint'($signed(b.max_x));
      hi[1] = longint'($signed(b.max_y));
      hi[2] = longint'($signed(b.max_z));
      culled = 1'b0;
      for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin
        pl = plane_e'(p);
        case (pl)
          PLANE_W_MINUS_X: begin row = 0; add = 1'b0; end
          PLANE_W_PLUS_X:  begin row = 0; add = 1'b1; end
          PLANE_W_PLUS_Y:  begin row = 1; add = 1'b1; end
          PLANE_W_MINUS_Y: begin row = 1; add = 1'b0; end
          PLANE_W_MINUS_Z: begin row = 2; add = 1'b0; end
          default:         begin row = 2; add = 1'b1; end
        endcase
        for (int c = 0; c < fbc_pkg::COL_COUNT; c++) begin
          coef[c] = add ? coefficient(c, W_ROW) + coefficient(c, row)
                        : coefficient(c, W_ROW) - coefficient(c, row);
        end
        // The constant is Q.12 and the products Q.20, so it is scaled up first.
        plane_dist = coef[W_COL] * longint'(1 << fbc_pkg::COORD_FRAC);
        // Take the box corner farthest along the normal; a zero entry takes min.
        for (int a = 0; a < fbc_pkg::AXIS_COUNT; a++) begin
          plane_dist += coef[a] * ((coef[a] > 0) ? hi[a] : lo[a]);
        end
        if (plane_dist < 0) culled = 1'b1;
      end
      return !culled;
    endfunction

    function void note_box(box_t b);
      verdict_t v;
      v.tag     = b.tag;
      v.visible = predict_visible(b);
      pending_verdicts = {pending_verdicts, v};
    endfunction

    function int unsigned outstanding();
      return pending_verdicts.size();
    endfunction

    function void flush();
      pending_verdicts.delete();
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
    endtask

    task check_result(logic [fbc_pkg::TAG_WIDTH-1:0] tag, logic visible);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with tag %h arrived with no request pending", tag));
        return;
      end
      want = pending_verdicts.pop_front();
      if (tag !== want.tag)
        report_mismatch($sformatf("tag %h, expected %h", tag, want.tag));
      if (visible !== want.visible)
        report_mismatch($sformatf("tag %h: visible %b, expected %b", want.tag, visible,
                                  want.visible));
    endtask
  endclass

endpackage

// ----- bench/testbench.sv -----
// Top of the frustum box cull bench: clock, reset, request and result drivers,
// directed and random stimulus over several matrix settings and idle patterns.
// Depends on fbc_pkg, cull_check_pkg and the frustum_box_cull_core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int TIMEOUT_CYCLES = 300000;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int LONG_HOLD      = 60;
  localparam int CHUNKS         = 4;
  localparam int CHUNK_ITEMS    = 34;

  localparam int Q8_ONE    = 256;
  localparam int Q12_ONE   = 4096;
  localparam int COORD_MAX = 8388607;
  localparam int COORD_MIN = -8388608;

  localparam int unsigned COORD_W = cull_check_pkg::COORD_W;

  localparam logic [fbc_pkg::CFG_IDX_WIDTH-1:0] REG_UNUSED_LOW  =
    fbc_pkg::REG_MATRIX_COL3 + 1'b1;
  localparam logic [fbc_pkg::CFG_IDX_WIDTH-1:0] REG_UNUSED_HIGH = '1;

  logic                              clk;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [fbc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i;
  logic [fbc_pkg::CFG_WIDTH-1:0]     cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [fbc_pkg::TAG_WIDTH-1:0]     node_tag_i;
  logic signed [COORD_W-1:0]         min_x_i, min_y_i, min_z_i;
  logic signed [COORD_W-1:0]         max_x_i, max_y_i, max_z_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [fbc_pkg::TAG_WIDTH-1:0]     tag_out_o;
  logic                              visible_o;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          long_hold_req;

  cull_check_pkg::cull_scoreboard sb = new();

  frustum_box_cull_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .node_tag_i  (node_tag_i),
    .min_x_i     (min_x_i),
    .min_y_i     (min_y_i),
    .min_z_i     (min_z_i),
    .max_x_i     (max_x_i),
    .max_y_i     (max_y_i),
    .max_z_i     (max_z_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tag_out_o   (tag_out_o),
    .visible_o   (visible_o)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Verification failed");
    $finish;
  end

  // Result side stall. The long hold is counted here so the sender keeps going.
  initial begin : result_stall
    int  held;
    bit  hold_used;
    held        = 0;
    hold_used   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_used) begin
        held      = LONG_HOLD;
        hold_used = 1'b1;
      end
      if (held > 0) begin
        out_stall_i = 1'b1;
        held--;
      end else begin
        out_stall_i = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(tag_out_o, visible_o);
  end

  function automatic logic [fbc_pkg::CFG_WIDTH-1:0] matrix_column(int r0, int r1, int r2,
                                                                   int r3);
    return {16'(r3), 16'(r2), 16'(r1), 16'(r0)};
  endfunction

  function automatic cull_check_pkg::box_t mk_box(logic [fbc_pkg::TAG_WIDTH-1:0] tag,
                                                  int lx, int ly, int lz,
                                                  int hx, int hy, int hz);
    cull_check_pkg::box_t b;
    b.tag   = tag;
    b.min_x = COORD_W'(lx);
    b.min_y = COORD_W'(ly);
    b.min_z = COORD_W'(lz);
    b.max_x = COORD_W'(hx);
    b.max_y = COORD_W'(hy);
    b.max_z = COORD_W'(hz);
    return b;
  endfunction

  // Mostly boxes near the origin, where the frustum edges are, plus some
  // points, a few inverted boxes and fully random bounds.
  function automatic cull_check_pkg::box_t random_box();
    int          lo [3];
    int          hi [3];
    int          ctr;
    int          half;
    int          swap_tmp;
    int unsigned kind;
    kind = $urandom_range(3);
    for (int a = 0; a < 3; a++) begin
      if (kind == 0) begin
        lo[a] = $urandom();
        hi[a] = $urandom();
      end else begin
        ctr   = int'($urandom_range(2048)) - 1024;
        half  = (kind == 3) ? 0 : int'($urandom_range(512));
        lo[a] = ctr - half;
        hi[a] = ctr + half;
        if ($urandom_range(15) == 0) begin
          swap_tmp = lo[a];
          lo[a]    = hi[a];
          hi[a]    = swap_tmp;
        end
      end
    end
    return mk_box($urandom(), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  // Called and returns just after a falling edge.
  task automatic send_box(cull_check_pkg::box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    in_valid_i = 1'b1;
    node_tag_i = b.tag;
    min_x_i    = b.min_x;
    min_y_i    = b.min_y;
    min_z_i    = b.min_z;
    max_x_i    = b.max_x;
    max_y_i    = b.max_y;
    max_z_i    = b.max_z;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sb.note_box(b);
    @(negedge clk);
  endtask

  task automatic drain();
    int unsigned waited;
    in_valid_i = 1'b0;
    waited     = 0;
    while (sb.outstanding() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (sb.outstanding() != 0) begin
      sb.report_mismatch($sformatf("%0d requests never answered", sb.outstanding()));
      sb.flush();
    end
  endtask

  task automatic write_cfg(logic [fbc_pkg::CFG_IDX_WIDTH-1:0] idx,
                           logic [fbc_pkg::CFG_WIDTH-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic apply_matrix(logic [fbc_pkg::CFG_WIDTH-1:0] c0,
                              logic [fbc_pkg::CFG_WIDTH-1:0] c1,
                              logic [fbc_pkg::CFG_WIDTH-1:0] c2,
                              logic [fbc_pkg::CFG_WIDTH-1:0] c3);
    drain();
    write_cfg(fbc_pkg::REG_MATRIX_COL0, c0);
    write_cfg(fbc_pkg::REG_MATRIX_COL1, c1);
    write_cfg(fbc_pkg::REG_MATRIX_COL2, c2);
    write_cfg(fbc_pkg::REG_MATRIX_COL3, c3);
    cfg_we_i = 1'b0;
  endtask

  // Projection-like matrices give a real frustum; the others stress the
  // arithmetic with arbitrary and extreme entries.
  task automatic apply_random_matrix();
    logic [fbc_pkg::CFG_WIDTH-1:0] col [fbc_pkg::COL_COUNT];
    logic [31:0]                   lane;
    int unsigned                   kind;
    kind = $urandom_range(2);
    for (int c = 0; c < fbc_pkg::COL_COUNT; c++) begin
      for (int r = 0; r < fbc_pkg::COL_COUNT; r++) begin
        if (kind == 0) begin
          lane = (c == r) ? $urandom_range(8192, 2048) : int'($urandom_range(512)) - 256;
        end else if (kind == 1) begin
          lane = $urandom();
        end else begin
          case ($urandom_range(4))
            0:       lane = '0;
            1:       lane = 32'h7fff;
            2:       lane = 32'h8000;
            3:       lane = 32'hffff;
            default: lane = $urandom();
          endcase
        end
        col[c][r*fbc_pkg::COEF_LANE +: fbc_pkg::COEF_LANE] = lane[fbc_pkg::COEF_LANE-1:0];
      end
    end
    apply_matrix(col[0], col[1], col[2], col[3]);
    if ($urandom_range(2) == 0) begin
      write_cfg(fbc_pkg::CFG_IDX_WIDTH'($urandom_range(REG_UNUSED_HIGH, REG_UNUSED_LOW)),
                {$urandom(), $urandom()});
      cfg_we_i = 1'b0;
    end
  endtask

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    node_tag_i    = '0;
    min_x_i       = '0;
    min_y_i       = '0;
    min_z_i       = '0;
    max_x_i       = '0;
    max_y_i       = '0;
    max_z_i       = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_req = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // The matrix is all zero after reset, so every box is visible.
    send_box(mk_box('0, 0, 0, 0, 0, 0, 0));
    send_box(mk_box('1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(mk_box(32'h3, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));

    // Identity matrix: the frustum is the cube from -1 to +1 on every axis.
    apply_matrix(matrix_column(Q12_ONE, 0, 0, 0), matrix_column(0, Q12_ONE, 0, 0),
                 matrix_column(0, 0, Q12_ONE, 0), matrix_column(0, 0, 0, Q12_ONE));
    send_box(mk_box(32'h4, -128, -128, -128, 128, 128, 128));
    // A point on a plane has distance zero and stays visible.
    send_box(mk_box(32'h5, Q8_ONE, 0, 0, Q8_ONE, 0, 0));
    send_box(mk_box(32'h6, Q8_ONE + 1, 0, 0, Q8_ONE + 1, 0, 0));
    send_box(mk_box(32'h7, -Q8_ONE, 0, 0, -Q8_ONE, 0, 0));
    send_box(mk_box(32'h8, 0, 0, -Q8_ONE - 1, 0, 0, -Q8_ONE - 1));
    // Inverted bounds are used as given, so this box is culled.
    send_box(mk_box(32'h9, 2 * Q8_ONE, 0, 0, -2 * Q8_ONE, 0, 0));
    send_box(mk_box(32'ha, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(mk_box(32'hb, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    // A write to an unused index must leave the matrix alone.
    drain();
    write_cfg(REG_UNUSED_HIGH, '1);
    cfg_we_i = 1'b0;
    send_box(mk_box(32'hc, Q8_ONE + 1, 0, 0, Q8_ONE + 1, 0, 0));

    // Zero normals: only the sign of the constant decides.
    apply_matrix('0, '0, '0, matrix_column(0, 0, 0, -Q12_ONE));
    send_box(mk_box(32'hd, -128, -128, -128, 128, 128, 128));
    send_box(mk_box(32'he, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    apply_matrix('0, '0, '0, matrix_column(0, 0, 0, Q12_ONE));
    send_box(mk_box(32'hf, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));

    // Extreme entries in every lane.
    apply_matrix({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}});
    send_box(mk_box(32'h10, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(mk_box(32'h11, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    apply_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    send_box(mk_box(32'h12, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(mk_box(32'h13, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    apply_matrix('1, '1, '1, '1);
    send_box(random_box());

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 26; recv_idle_pct = 78; end
        1:       begin send_idle_pct = 78; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        apply_random_matrix();
        // Hold results off for a long stretch so the pipeline backs up.
        if (ph == 2 && chunk == 1) long_hold_req = 1'b1;
        repeat (CHUNK_ITEMS) send_box(random_box());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/fbc_pkg.sv
sv/fbc_plane.sv
sv/frustum_box_cull_core.sv
sv/fbc_checker.sv
bench/cull_check_pkg.sv
bench/testbench.sv
